// ----- hw/rtl/cee_pkg.sv -----
// Shared constants and types for the cursor escape expander.
`timescale 1ns / 1ps

package cee_pkg;

   // Default build values
   localparam int OUT_LIMIT_DEF   = 56;
   localparam int PARAM_WIDTH_DEF = 16;

   // Decimal conversion: values clamp to 0..99999, five BCD digits
   localparam int DEC_CAP    = 99999;
   localparam int DEC_BITS   = 17;
   localparam int BCD_DIGITS = 5;

   // Template characters
   localparam logic [7:0] CH_NUL  = 8'h00;
   localparam logic [7:0] CH_PCT  = 8'h25; // '%'
   localparam logic [7:0] CH_PLUS = 8'h2B; // '+'
   localparam logic [7:0] CH_DOT  = 8'h2E; // '.'
   localparam logic [7:0] CH_ZERO = 8'h30; // '0'
   localparam logic [7:0] CH_TWO  = 8'h32; // '2'
   localparam logic [7:0] CH_THR  = 8'h33; // '3'
   localparam logic [7:0] CH_NINE = 8'h39; // '9'
   localparam logic [7:0] CH_D    = 8'h64; // 'd'
   localparam logic [7:0] CH_I    = 8'h69; // 'i'
   localparam logic [7:0] CH_R    = 8'h72; // 'r'

   // Control sequencer
   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CONV  = 4'b0010,
      ST_DIGIT = 4'b0100,
      ST_TERM  = 4'b1000
   } state_type;

   // Escape parser phase
   typedef enum logic [2:0] {
      PH_PLAIN = 3'b001,
      PH_ESC   = 3'b010,
      PH_PLUS  = 3'b100
   } phase_type;

endpackage

// ----- hw/rtl/cursor_escape_expander_core.sv -----
// Termcap cursor-motion template expander, one template byte per input item.
`timescale 1ns / 1ps
// A plain byte, %., %+x, %%, an error or a terminator is loaded into the output register
// as the item is accepted; %+ with a zero byte loads the byte, then the terminator (ST_TERM).
// Decimal escapes run a bit-serial binary-to-BCD shifter (ST_CONV), then five digit steps
// (ST_DIGIT) emit at most one byte each, skipping leading zeros; a step waits for a free output.
// One item is in work at a time; the output register must be free or draining to accept.
// Reset (synchronous, active high) clears parameters, phase, count, halt and the output valid.

module cursor_escape_expander_core #(
   parameter int OUT_LIMIT   = cee_pkg::OUT_LIMIT_DEF,
   parameter int PARAM_WIDTH = cee_pkg::PARAM_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // input items
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [7:0] ch, [8 +: PARAM_WIDTH] row, [8+PARAM_WIDTH +: PARAM_WIDTH] col, zero pad
   input  logic [((8 + 2*PARAM_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                  req_tuser,  // [0] start_req
   // result items
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,  // [7:0] out_byte
   output logic                  rsp_tlast,  // last
   output logic                  rsp_tuser   // [0] error
);

   localparam int VAL_W  = PARAM_WIDTH + 1;
   localparam int DEC_W  = cee_pkg::DEC_BITS;
   localparam int EXT_W  = (VAL_W > DEC_W + 1) ? VAL_W : DEC_W + 1;
   localparam int BCD_W  = 4 * cee_pkg::BCD_DIGITS;
   localparam int CCNT_W = $clog2(cee_pkg::DEC_BITS);
   localparam int POS_W  = $clog2(cee_pkg::BCD_DIGITS);
   localparam int CNT_W  = $clog2(OUT_LIMIT + 8);

   localparam logic signed [EXT_W-1:0] CAP_EXT  = EXT_W'(cee_pkg::DEC_CAP);
   localparam logic signed [VAL_W-1:0] PARAM_MAX = {1'b0, {PARAM_WIDTH{1'b1}}};

   // ---------------------------------------------------------------- state
   cee_pkg::state_type state_ff, state_in;
   cee_pkg::phase_type phase_ff, phase_in;

   logic signed [VAL_W-1:0] p1_ff, p1_in;      // first parameter
   logic signed [VAL_W-1:0] p2_ff, p2_in;      // second parameter
   logic                    sel_ff, sel_in;    // 0: first param current, 1: second (sticky)
   logic [CNT_W-1:0]        cnt_ff, cnt_in;    // data bytes emitted this template
   logic                    halted_ff, halted_in;

   // decimal conversion datapath
   logic [DEC_W-1:0]        conv_ff, conv_in;  // binary shifted out MSB first
   logic [BCD_W-1:0]        bcd_ff, bcd_in;
   logic [CCNT_W-1:0]       ccnt_ff, ccnt_in;
   logic [POS_W-1:0]        pos_ff, pos_in;    // digit position being emitted
   logic [1:0]              min_ff, min_in;    // minimum digit count
   logic                    seen_ff, seen_in;  // a digit has already been printed

   // output register
   logic                    rsp_valid_ff;
   logic [7:0]              rsp_byte_ff;
   logic                    rsp_last_ff, rsp_err_ff;

   logic                    out_load;
   logic [7:0]              out_byte_in;
   logic                    out_last_in, out_err_in;
   logic                    cnt_inc;

   // ---------------------------------------------------------------- input fields
   logic                    in_acc;
   logic                    start;
   logic [7:0]              ch;
   logic [PARAM_WIDTH-1:0]  row, col;

   assign ch    = req_tdata[7:0];
   assign row   = req_tdata[8 +: PARAM_WIDTH];
   assign col   = req_tdata[8 + PARAM_WIDTH +: PARAM_WIDTH];
   assign start = req_tuser;

   logic out_free;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == cee_pkg::ST_IDLE) && out_free;
   assign in_acc     = req_tvalid && req_tready;

   // state as seen by this item after a start has been applied
   logic signed [VAL_W-1:0] p1_eff, p2_eff, cur;
   logic                    sel_eff, halted_eff;
   logic [CNT_W-1:0]        cnt_eff;
   cee_pkg::phase_type      phase_eff;

   assign p1_eff     = start ? VAL_W'(signed'(row)) : p1_ff;
   assign p2_eff     = start ? VAL_W'(signed'(col)) : p2_ff;
   assign sel_eff    = start ? 1'b0 : sel_ff;
   assign halted_eff = start ? 1'b0 : halted_ff;
   assign cnt_eff    = start ? '0 : cnt_ff;
   assign phase_eff  = start ? cee_pkg::PH_PLAIN : phase_ff;
   assign cur        = sel_eff ? p2_eff : p1_eff;

   // clamp to 0..99999 for decimal output
   logic signed [EXT_W-1:0] cur_ext;
   logic [DEC_W-1:0]        clamped;
   assign cur_ext = EXT_W'(cur);
   assign clamped = cur_ext[EXT_W-1]  ? '0 :
                    (cur_ext > CAP_EXT) ? DEC_W'(cee_pkg::DEC_CAP) :
                    cur_ext[DEC_W-1:0];

   // saturating increment for %i
   logic signed [VAL_W-1:0] p1_inc, p2_inc;
   assign p1_inc = (p1_eff < PARAM_MAX) ? p1_eff + VAL_W'(1) : p1_eff;
   assign p2_inc = (p2_eff < PARAM_MAX) ? p2_eff + VAL_W'(1) : p2_eff;

   // one double-dabble step: add 3 to every digit >= 5, shift in next binary bit
   logic [BCD_W-1:0] bcd_adj, bcd_shift;
   logic [3:0]       dab_dig;
   always_comb begin
      dab_dig = '0;
      for (int i = 0; i < cee_pkg::BCD_DIGITS; i++) begin
         dab_dig            = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4]  = (dab_dig >= 4'd5) ? dab_dig + 4'd3 : dab_dig;
      end
      bcd_shift = {bcd_adj[BCD_W-2:0], conv_ff[DEC_W-1]};
   end

   // digit emission: top nibble of the BCD shifter
   logic [3:0] digit;
   logic       digit_emit;
   assign digit      = bcd_ff[BCD_W-1 -: 4];
   assign digit_emit = seen_ff || (digit != 4'd0) || (pos_ff < POS_W'(min_ff));

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in    = state_ff;
      phase_in    = phase_ff;
      p1_in       = p1_ff;
      p2_in       = p2_ff;
      sel_in      = sel_ff;
      cnt_in      = cnt_ff;
      halted_in   = halted_ff;
      conv_in     = conv_ff;
      bcd_in      = bcd_ff;
      ccnt_in     = ccnt_ff;
      pos_in      = pos_ff;
      min_in      = min_ff;
      seen_in     = seen_ff;
      out_load    = 1'b0;
      out_byte_in = cee_pkg::CH_NUL;
      out_last_in = 1'b0;
      out_err_in  = 1'b0;
      cnt_inc     = 1'b0;

      unique case (state_ff)
         cee_pkg::ST_IDLE: begin
            if (in_acc) begin
               p1_in     = p1_eff;
               p2_in     = p2_eff;
               sel_in    = sel_eff;
               cnt_in    = cnt_eff;
               halted_in = halted_eff;
               phase_in  = phase_eff;
               if (!halted_eff) begin
                  phase_in = cee_pkg::PH_PLAIN;
                  case (phase_eff)
                     cee_pkg::PH_ESC: begin
                        unique case (ch) inside
                           cee_pkg::CH_D, cee_pkg::CH_TWO, cee_pkg::CH_THR: begin
                              conv_in  = clamped;
                              bcd_in   = '0;
                              ccnt_in  = CCNT_W'(cee_pkg::DEC_BITS - 1);
                              pos_in   = POS_W'(cee_pkg::BCD_DIGITS - 1);
                              seen_in  = 1'b0;
                              min_in   = (ch == cee_pkg::CH_TWO) ? 2'd2 :
                                         (ch == cee_pkg::CH_THR) ? 2'd3 : 2'd1;
                              sel_in   = 1'b1;
                              state_in = cee_pkg::ST_CONV;
                           end
                           cee_pkg::CH_DOT: begin
                              out_load    = 1'b1;
                              out_byte_in = cur[7:0];
                              cnt_inc     = 1'b1;
                              sel_in      = 1'b1;
                           end
                           cee_pkg::CH_PLUS: begin
                              phase_in = cee_pkg::PH_PLUS;
                           end
                           cee_pkg::CH_I: begin
                              p1_in = p1_inc;
                              p2_in = p2_inc;
                           end
                           cee_pkg::CH_R: begin
                              p1_in = p2_eff;
                              p2_in = p1_eff;
                           end
                           cee_pkg::CH_PCT: begin
                              out_load    = 1'b1;
                              out_byte_in = cee_pkg::CH_PCT;
                              cnt_inc     = 1'b1;
                           end
                           default: begin
                              // unknown escape or NUL after '%'
                              out_load    = 1'b1;
                              out_last_in = 1'b1;
                              out_err_in  = 1'b1;
                              halted_in   = 1'b1;
                           end
                        endcase
                     end
                     cee_pkg::PH_PLUS: begin
                        out_load    = 1'b1;
                        out_byte_in = cur[7:0] + ch;
                        cnt_inc     = 1'b1;
                        sel_in      = 1'b1;
                        if (ch == cee_pkg::CH_NUL) begin
                           // NUL operand: byte goes out, terminator follows
                           halted_in = 1'b1;
                           state_in  = cee_pkg::ST_TERM;
                        end
                     end
                     default: begin
                        if (ch == cee_pkg::CH_NUL) begin
                           out_load    = 1'b1;
                           out_last_in = 1'b1;
                           halted_in   = 1'b1;
                        end else if (cnt_eff >= CNT_W'(OUT_LIMIT)) begin
                           // over the output limit: byte dropped
                        end else if (ch == cee_pkg::CH_PCT) begin
                           phase_in = cee_pkg::PH_ESC;
                        end else begin
                           out_load    = 1'b1;
                           out_byte_in = ch;
                           cnt_inc     = 1'b1;
                        end
                     end
                  endcase
               end
            end
         end

         cee_pkg::ST_CONV: begin
            bcd_in  = bcd_shift;
            conv_in = conv_ff << 1;
            if (ccnt_ff == '0) begin
               state_in = cee_pkg::ST_DIGIT;
            end else begin
               ccnt_in = ccnt_ff - 1'b1;
            end
         end

         cee_pkg::ST_DIGIT: begin
            if (!digit_emit || out_free) begin
               if (digit_emit) begin
                  out_load    = 1'b1;
                  out_byte_in = cee_pkg::CH_ZERO + {4'd0, digit};
                  cnt_inc     = 1'b1;
                  seen_in     = 1'b1;
               end
               bcd_in = bcd_ff << 4;
               if (pos_ff == '0) begin
                  state_in = cee_pkg::ST_IDLE;
               end else begin
                  pos_in = pos_ff - 1'b1;
               end
            end
         end

         cee_pkg::ST_TERM: begin
            if (out_free) begin
               out_load    = 1'b1;
               out_last_in = 1'b1;
               state_in    = cee_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = cee_pkg::ST_IDLE;
         end
      endcase

      // saturating emitted-byte count
      if (cnt_inc && (cnt_in != '1)) begin
         cnt_in = cnt_in + 1'b1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cee_pkg::ST_IDLE;
         phase_ff     <= cee_pkg::PH_PLAIN;
         p1_ff        <= '0;
         p2_ff        <= '0;
         sel_ff       <= 1'b0;
         cnt_ff       <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         p1_ff     <= p1_in;
         p2_ff     <= p2_in;
         sel_ff    <= sel_in;
         cnt_ff    <= cnt_in;
         halted_ff <= halted_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      conv_ff <= conv_in;
      bcd_ff  <= bcd_in;
      ccnt_ff <= ccnt_in;
      pos_ff  <= pos_in;
      min_ff  <= min_in;
      seen_ff <= seen_in;
      if (out_load) begin
         rsp_byte_ff <= out_byte_in;
         rsp_last_ff <= out_last_in;
         rsp_err_ff  <= out_err_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

   // ---------------------------------------------------------------- checks
`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("output register overwritten while holding an item");

   a_conv_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cee_pkg::ST_CONV) |-> !out_load)
      else $error("result loaded during BCD conversion");

   a_conv_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == cee_pkg::ST_CONV) && (ccnt_ff == '0) |=> (state_ff == cee_pkg::ST_DIGIT))
      else $error("conversion did not hand over to digit output");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      out_load && (state_ff == cee_pkg::ST_DIGIT) |->
         (out_byte_in >= cee_pkg::CH_ZERO) && (out_byte_in <= cee_pkg::CH_NINE))
      else $error("decimal digit out of range");

   a_halted_quiet: assert property (@(posedge clock) disable iff (reset)
      in_acc && halted_ff && !start |-> !out_load && (state_in == cee_pkg::ST_IDLE))
      else $error("halted template produced a result");
`endif

endmodule

// ----- test/tb.sv -----
// Self-checking testbench for the cursor escape expander core.
`timescale 1ns / 1ps

module tb;

   localparam int     PW        = cee_pkg::PARAM_WIDTH_DEF;
   localparam int     REQ_W     = ((8 + 2*PW + 7) / 8) * 8;
   localparam longint PARAM_MAX = (longint'(1) << PW) - 1;

   // one template byte as the sender sees it
   typedef struct {
      logic                 start;
      logic [7:0]           ch;
      logic signed [PW-1:0] row;
      logic signed [PW-1:0] col;
   } tmpl_item_type;

   // one expanded output item
   typedef struct {
      logic [7:0] out_byte;
      logic       last;
      logic       err;
   } exp_byte_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;   // [7:0] ch, [23:8] row, [39:24] col
   logic             req_tuser = 1'b0; // [0] start_req
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [7:0]       rsp_tdata;        // [7:0] out_byte
   logic             rsp_tlast;
   logic             rsp_tuser;        // [0] error

   cursor_escape_expander_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // template bytes waiting to be sent, and expansion bytes waiting to be seen
   tmpl_item_type pending_q[$];
   exp_byte_type  expected_q[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count    = 0;
   int items_sent    = 0;
   int bytes_seen    = 0;
   int terms_seen    = 0;
   int errors_seen   = 0;
   int limit_hits    = 0;

   // ------------------------------------------------------------------
   // Expansion model: private copy of the parameter/escape state
   // ------------------------------------------------------------------
   longint             tpl_first   = 0;
   longint             tpl_second  = 0;
   int unsigned        tpl_index   = 0;
   cee_pkg::phase_type tpl_phase   = cee_pkg::PH_PLAIN;
   int unsigned        tpl_emitted = 0;
   bit                 tpl_halted  = 1'b0;

   function automatic void note_result(logic [7:0] b, logic lst, logic er);
      exp_byte_type r;
      r.out_byte = b;
      r.last     = lst;
      r.err      = er;
      expected_q.push_back(r);
   endfunction

   // data bytes count toward the output limit; the count saturates at 63
   function automatic void note_data(logic [7:0] b);
      note_result(b, 1'b0, 1'b0);
      if (tpl_emitted < 63) tpl_emitted++;
   endfunction

   function automatic longint cur_param();
      return (tpl_index == 0) ? tpl_first : tpl_second;
   endfunction

   function automatic void advance_param();
      if (tpl_index < 2) tpl_index++;
   endfunction

   function automatic longint sat_inc(longint p);
      return (p < PARAM_MAX) ? p + 1 : p;
   endfunction

   // decimal: clamp to 0..DEC_CAP, pad with leading zeros to min_digits
   function automatic void note_decimal(longint value, int min_digits);
      logic [7:0]  digits[cee_pkg::BCD_DIGITS];
      int          k;
      int unsigned v;
      if (value < 0) value = 0;
      if (value > cee_pkg::DEC_CAP) value = cee_pkg::DEC_CAP;
      v = int'(value);
      k = 0;
      do begin
         digits[k] = cee_pkg::CH_ZERO + 8'(v % 10);
         v = v / 10;
         k++;
      end while ((v != 0 || k < min_digits) && k < cee_pkg::BCD_DIGITS);
      while (k > 0) begin
         k--;
         note_data(digits[k]);
      end
   endfunction

   function automatic void expand_item(tmpl_item_type it);
      longint t;
      if (it.start) begin
         tpl_first   = longint'(it.row);
         tpl_second  = longint'(it.col);
         tpl_index   = 0;
         tpl_phase   = cee_pkg::PH_PLAIN;
         tpl_emitted = 0;
         tpl_halted  = 1'b0;
      end
      if (tpl_halted) return;

      case (tpl_phase)
         cee_pkg::PH_ESC: begin
            tpl_phase = cee_pkg::PH_PLAIN;
            case (it.ch)
               cee_pkg::CH_D, cee_pkg::CH_TWO, cee_pkg::CH_THR: begin
                  note_decimal(cur_param(), (it.ch == cee_pkg::CH_TWO) ? 2 :
                                            ((it.ch == cee_pkg::CH_THR) ? 3 : 1));
                  advance_param();
               end
               cee_pkg::CH_DOT: begin
                  note_data(8'(cur_param()));
                  advance_param();
               end
               cee_pkg::CH_PLUS: tpl_phase = cee_pkg::PH_PLUS;
               cee_pkg::CH_I: begin
                  tpl_first  = sat_inc(tpl_first);
                  tpl_second = sat_inc(tpl_second);
               end
               cee_pkg::CH_R: begin
                  t          = tpl_first;
                  tpl_first  = tpl_second;
                  tpl_second = t;
               end
               cee_pkg::CH_PCT: note_data(cee_pkg::CH_PCT);
               default: begin
                  // unknown escape or NUL right after '%'
                  note_result(8'h00, 1'b1, 1'b1);
                  tpl_halted = 1'b1;
               end
            endcase
         end
         cee_pkg::PH_PLUS: begin
            tpl_phase = cee_pkg::PH_PLAIN;
            note_data(8'(cur_param() + longint'(it.ch)));
            advance_param();
            if (it.ch == cee_pkg::CH_NUL) begin
               // NUL after %+ adds zero and also ends the template
               note_result(8'h00, 1'b1, 1'b0);
               tpl_halted = 1'b1;
            end
         end
         default: begin
            tpl_phase = cee_pkg::PH_PLAIN;
            if (it.ch == cee_pkg::CH_NUL) begin
               note_result(8'h00, 1'b1, 1'b0);
               tpl_halted = 1'b1;
            end else if (tpl_emitted >= cee_pkg::OUT_LIMIT_DEF) begin
               limit_hits++;   // dropped at the output limit
            end else if (it.ch == cee_pkg::CH_PCT) begin
               tpl_phase = cee_pkg::PH_ESC;
            end else begin
               note_data(it.ch);
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Driver: pops template bytes, holds each until accepted
   // ------------------------------------------------------------------
   tmpl_item_type drive_item;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expand_item(drive_item);
            items_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               drive_item = pending_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {drive_item.col, drive_item.row, drive_item.ch};
               req_tuser  <= drive_item.start;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Monitor: random backpressure, in-order compare of each output item
   // ------------------------------------------------------------------
   exp_byte_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_tvalid && rsp_tready) begin
            bytes_seen++;
            if (rsp_tlast) terms_seen++;
            if (rsp_tuser) errors_seen++;
            if (expected_q.size() == 0) begin
               $error("output item with nothing expected: out_byte %02h last %0b error %0b",
                      rsp_tdata, rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte mismatch: expected %02h, actual %02h",
                         want.out_byte, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last mismatch: expected %0b, actual %0b", want.last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== want.err) begin
                  $error("error mismatch: expected %0b, actual %0b", want.err, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   bit                   stim_start = 1'b0;
   logic signed [PW-1:0] stim_row;
   logic signed [PW-1:0] stim_col;
   int                   stim_pushed = 0;

   // row/col are only latched on start; other items carry random noise there
   task automatic push_ch(logic [7:0] c);
      tmpl_item_type it;
      it.start = stim_start;
      it.ch    = c;
      it.row   = stim_start ? stim_row : PW'($urandom);
      it.col   = stim_start ? stim_col : PW'($urandom);
      stim_start = 1'b0;
      pending_q.push_back(it);
      stim_pushed++;
   endtask

   task automatic begin_template(logic signed [PW-1:0] r, logic signed [PW-1:0] c);
      stim_start = 1'b1;
      stim_row   = r;
      stim_col   = c;
   endtask

   task automatic push_esc(logic [7:0] c);
      push_ch(cee_pkg::CH_PCT);
      push_ch(c);
   endtask

   function automatic logic signed [PW-1:0] rand_param();
      case ($urandom_range(5))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return PW'($urandom_range(200));
         3:       return PW'(0 - $urandom_range(1, 5));
         default: return PW'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255)); while (c == cee_pkg::CH_PCT);
      return c;
   endfunction

   function automatic logic [7:0] bad_escape();
      logic [7:0] c;
      do c = 8'($urandom_range(1, 255));
      while (c inside {cee_pkg::CH_D, cee_pkg::CH_TWO, cee_pkg::CH_THR, cee_pkg::CH_DOT,
                       cee_pkg::CH_PLUS, cee_pkg::CH_I, cee_pkg::CH_R, cee_pkg::CH_PCT});
      return c;
   endfunction

   // one piece of a template: a plain byte or one escape
   task automatic gen_segment(bit long_tpl);
      case ($urandom_range(15))
         5:  push_esc(cee_pkg::CH_D);
         6:  push_esc(cee_pkg::CH_TWO);
         7:  push_esc(cee_pkg::CH_THR);
         8:  push_esc(cee_pkg::CH_DOT);
         9: begin
            push_esc(cee_pkg::CH_PLUS);
            push_ch(8'($urandom_range(1, 255)));
         end
         10: push_esc(cee_pkg::CH_I);
         11: push_esc(cee_pkg::CH_R);
         12: push_esc(cee_pkg::CH_PCT);
         13, 14, 15: begin
            // long templates lean on decimals to reach the output limit fast
            if (long_tpl) push_esc(cee_pkg::CH_D);
            else push_ch(plain_byte());
         end
         default: push_ch(plain_byte());
      endcase
   endtask

   // mostly well-formed templates; some end badly, some never end
   task automatic gen_template();
      bit long_tpl;
      int nseg;
      long_tpl = ($urandom_range(5) == 0);
      nseg     = long_tpl ? $urandom_range(20, 35) : $urandom_range(0, 8);
      begin_template(rand_param(), rand_param());
      repeat (nseg) gen_segment(long_tpl);
      case ($urandom_range(9))
         0: push_esc(bad_escape());
         1: push_esc(cee_pkg::CH_NUL);
         2: begin
            push_esc(cee_pkg::CH_PLUS);
            push_ch(cee_pkg::CH_NUL);
         end
         3: ;   // cut short: the next start takes over mid-template
         default: push_ch(cee_pkg::CH_NUL);
      endcase
      // stray bytes after the end; ignored when the template has halted
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) push_ch(8'($urandom));
   endtask

   task automatic gen_random(int n);
      int goal;
      goal = stim_pushed + n;
      while (stim_pushed < goal) gen_template();
   endtask

   // sender holds off until every outstanding item has gone through
   task automatic wait_drained();
      @(negedge clock);
      while (pending_q.size() != 0 || req_tvalid || expected_q.size() != 0) @(negedge clock);
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // phase 1: slow sender, heavily stalled receiver
      send_idle_pct = 26;
      recv_idle_pct = 85;

      // bytes before any start run with both parameters at zero
      push_ch(8'h41);
      push_esc(cee_pkg::CH_D);

      // negative clamps to 0; index moves to col = max positive
      begin_template(-16'sd5, 16'sh7FFF);
      push_esc(cee_pkg::CH_D);
      push_esc(cee_pkg::CH_TWO);
      push_ch(cee_pkg::CH_NUL);

      // %i then %r, padded decimal, raw byte, add with 0xFF, literal percent
      begin_template(16'sd7, 16'sh8000);
      push_esc(cee_pkg::CH_I);
      push_esc(cee_pkg::CH_R);
      push_esc(cee_pkg::CH_THR);
      push_esc(cee_pkg::CH_DOT);
      push_esc(cee_pkg::CH_PLUS);
      push_ch(8'hFF);
      push_esc(cee_pkg::CH_PCT);
      push_ch(cee_pkg::CH_NUL);

      // NUL right after %+ : byte then terminator
      begin_template(-16'sd1, 16'sd300);
      push_esc(cee_pkg::CH_PLUS);
      push_ch(cee_pkg::CH_NUL);

      // NUL right after % is an error; following byte is ignored
      begin_template(16'sd200, 16'sd0);
      push_esc(cee_pkg::CH_NUL);
      push_ch(8'h7A);

      gen_random(110);
      wait_drained();

      // phase 2: roles swapped
      send_idle_pct = 85;
      recv_idle_pct = 26;
      gen_random(110);
      wait_drained();

      // phase 3: no idling on either side
      send_idle_pct = 0;
      recv_idle_pct = 0;
      gen_random(110);

      wait_drained();
      // decimal escapes keep the core busy after acceptance
      repeat (40) @(negedge clock);

      if (expected_q.size() != 0) begin
         $error("%0d expected output items never arrived", expected_q.size());
         fail_count++;
      end

      $display("Sent %0d template bytes over three pacing modes, draining between them.",
               items_sent);
      $display("Checked %0d output bytes: %0d ends, %0d bad-escape errors, %0d drops at the limit.",
               bytes_seen, terms_seen, errors_seen, limit_hits);
      if (fail_count == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #10_000_000;
      $display("tb failed");
      $finish;
   end

endmodule

// ----- cursor_escape_expander_core.f -----
hw/rtl/cee_pkg.sv
hw/rtl/cursor_escape_expander_core.sv
test/tb.sv
